### hdl/branch_and_condition_unit_assert.svh
// ----------------------------------------------------------------------------
// branch and condition unit assertion macros
// clocked concurrent assertion wrappers shared by the checker
// ----------------------------------------------------------------------------
`ifndef BRANCH_AND_CONDITION_UNIT_ASSERT_SVH
`define BRANCH_AND_CONDITION_UNIT_ASSERT_SVH

// generic form, clock and active-low reset given explicitly
`define BCU_ASSERT_CLK(lbl, ck, rstn, prop) \
	lbl: assert property (@(posedge ck) disable iff (!rstn) prop) \
		else $error("bcu assertion failed");

// block clock and reset
`define BCU_ASSERT(lbl, prop) \
	`BCU_ASSERT_CLK(lbl, clk, arst_n, prop)

`endif

### hdl/bcu_pkg.sv
// ----------------------------------------------------------------------------
// bcu_pkg
// shared types and constants of the branch and condition unit
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package bcu_pkg;

	localparam int unsigned XLEN      = 32;
	localparam int unsigned DISP_W    = 26;
	localparam int unsigned FIELD_W   = 5;
	localparam int unsigned IN_DATA_W = 88;
	localparam int unsigned OUT_DATA_W = 136;

	localparam logic [XLEN-1:0] ADDR_MASK = 32'hFFFF_FFFC;
	localparam logic [XLEN-1:0] PC_STEP   = 32'd4;
	localparam logic [3:0]      CR_FIELD_MASK = 4'b1111;

	// BO bit positions (bit 0 is the lsb here)
	localparam int unsigned BO_CTR_ZERO = 1;
	localparam int unsigned BO_NO_DEC   = 2;
	localparam int unsigned BO_COND_VAL = 3;
	localparam int unsigned BO_NO_COND  = 4;

	typedef enum logic [3:0] {
		OP_B      = 4'd0,
		OP_BC     = 4'd1,
		OP_BCLR   = 4'd2,
		OP_BCCTR  = 4'd3,
		OP_CRAND  = 4'd4,
		OP_CRANDC = 4'd5,
		OP_CREQV  = 4'd6,
		OP_CROR   = 4'd7,
		OP_CRORC  = 4'd8,
		OP_CRNAND = 4'd9,
		OP_CRNOR  = 4'd10,
		OP_CRXOR  = 4'd11,
		OP_MCRF   = 4'd12
	} op_t;

	typedef struct packed {
		op_t                       operation;
		logic [XLEN-1:0]           cur_pc;
		logic signed [DISP_W-1:0]  displacement;
		logic [FIELD_W-1:0]        branch_options;
		logic [FIELD_W-1:0]        cond_bit;
		logic                      absolute;
		logic                      link;
		logic [FIELD_W-1:0]        dest_bit;
		logic [FIELD_W-1:0]        src_a_bit;
		logic [FIELD_W-1:0]        src_b_bit;
	} item_t;

	typedef struct packed {
		logic [XLEN-1:0] next_pc;
		logic [XLEN-1:0] link_out;
		logic [XLEN-1:0] count_out;
		logic [XLEN-1:0] cond_out;
		logic            taken;
		logic            invalid;
		logic            return_event;
	} result_t;

	typedef struct packed {
		logic [XLEN-1:0] cond;
		logic [XLEN-1:0] count;
		logic [XLEN-1:0] link;
	} arch_t;

endpackage

`default_nettype wire

### hdl/bcu_exec.sv
// ----------------------------------------------------------------------------
// bcu_exec
// combinational execute: branch resolution, cr bit logic and field move
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bcu_exec (
	input  bcu_pkg::item_t   item,
	input  bcu_pkg::arch_t   arch,
	output bcu_pkg::arch_t   arch_n,
	output bcu_pkg::result_t res
);
	import bcu_pkg::*;

	logic [XLEN-1:0] disp_ext;
	logic [XLEN-1:0] br_target;
	logic [XLEN-1:0] pc_plus4;
	logic [XLEN-1:0] ctr_dec;
	logic [XLEN-1:0] count_after;
	logic            dec;
	logic            ctr_ok;
	logic            cond_ok;
	logic            bo_go;
	logic            bit_a;
	logic            bit_b;
	logic            cr_result;
	logic [4:0]      src_shift;
	logic [4:0]      dst_shift;
	logic [XLEN-1:0] src_shifted;
	logic [3:0]      src_field;
	logic [XLEN-1:0] mcrf_cond;
	logic            br_valid;
	logic            br_go;
	logic [XLEN-1:0] br_tgt;

	assign disp_ext  = {{(XLEN-DISP_W){item.displacement[DISP_W-1]}}, item.displacement};
	assign br_target = item.absolute ? disp_ext : item.cur_pc + disp_ext;
	assign pc_plus4  = item.cur_pc + PC_STEP;

	// bo rules: optional count decrement and test, optional cr bit test
	assign dec         = !item.branch_options[BO_NO_DEC];
	assign ctr_dec     = arch.count - 32'd1;
	assign ctr_ok      = !dec || ((ctr_dec == '0) == item.branch_options[BO_CTR_ZERO]);
	assign cond_ok     = item.branch_options[BO_NO_COND] ||
	                     (arch.cond[~item.cond_bit] == item.branch_options[BO_COND_VAL]);
	assign bo_go       = ctr_ok && cond_ok;
	assign count_after = dec ? ctr_dec : arch.count;

	// cr bit 0 is the msb, so bit i sits at position 31 - i
	assign bit_a = arch.cond[~item.src_a_bit];
	assign bit_b = arch.cond[~item.src_b_bit];

	always_comb begin
		case (item.operation)
			OP_CRAND:  cr_result = bit_a & bit_b;
			OP_CRANDC: cr_result = bit_a & !bit_b;
			OP_CREQV:  cr_result = !(bit_a ^ bit_b);
			OP_CROR:   cr_result = bit_a | bit_b;
			OP_CRORC:  cr_result = bit_a | !bit_b;
			OP_CRNAND: cr_result = !(bit_a & bit_b);
			OP_CRNOR:  cr_result = !(bit_a | bit_b);
			default:   cr_result = bit_a ^ bit_b;
		endcase
	end

	// field f occupies bits 4*(7-f) upward
	assign src_shift   = {~item.src_a_bit[2:0], 2'b00};
	assign dst_shift   = {~item.dest_bit[2:0], 2'b00};
	assign src_shifted = arch.cond >> src_shift;
	assign src_field   = src_shifted[3:0];
	assign mcrf_cond   = (arch.cond & ~({28'd0, CR_FIELD_MASK} << dst_shift)) |
	                     ({28'd0, src_field} << dst_shift);

	always_comb begin
		arch_n           = arch;
		res.next_pc      = item.cur_pc;
		res.taken        = 1'b0;
		res.invalid      = 1'b0;
		res.return_event = 1'b0;
		br_valid         = 1'b0;
		br_go            = 1'b0;
		br_tgt           = br_target;

		unique case (item.operation) inside
			OP_B: begin
				br_valid = 1'b1;
				br_go    = 1'b1;
			end
			OP_BC: begin
				br_valid     = 1'b1;
				br_go        = bo_go;
				arch_n.count = count_after;
			end
			OP_BCLR: begin
				br_valid         = 1'b1;
				br_go            = bo_go;
				br_tgt           = arch.link;
				arch_n.count     = count_after;
				res.return_event = bo_go && item.branch_options[BO_NO_DEC];
			end
			OP_BCCTR: begin
				// decrementing form is not allowed: no state change
				if (dec) begin
					res.invalid = 1'b1;
				end else begin
					br_valid = 1'b1;
					br_go    = bo_go;
					br_tgt   = arch.count;
				end
			end
			[OP_CRAND:OP_CRXOR]: begin
				arch_n.cond[~item.dest_bit] = cr_result;
			end
			OP_MCRF: begin
				arch_n.cond = mcrf_cond;
			end
			default: ;
		endcase

		if (br_valid) begin
			if (item.link) begin
				arch_n.link = pc_plus4 & ADDR_MASK;
			end
			if (br_go) begin
				res.next_pc = br_tgt & ADDR_MASK;
				res.taken   = 1'b1;
			end else begin
				res.next_pc = pc_plus4;
			end
		end

		res.link_out  = arch_n.link;
		res.count_out = arch_n.count;
		res.cond_out  = arch_n.cond;
	end

endmodule

`default_nettype wire

### hdl/bcu_arch_regs.sv
// ----------------------------------------------------------------------------
// bcu_arch_regs
// condition, count and link registers
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bcu_arch_regs (
	input  wire             clk,
	input  wire             arst_n,
	input  wire             load,
	input  bcu_pkg::arch_t  arch_n,
	output bcu_pkg::arch_t  arch
);
	import bcu_pkg::*;

	arch_t arch_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			arch_q <= '0;
		end else if (load) begin
			arch_q <= arch_n;
		end
	end

	assign arch = arch_q;

endmodule

`default_nettype wire

### hdl/branch_and_condition_unit.sv
// ----------------------------------------------------------------------------
// branch_and_condition_unit
// branch resolution and condition register logic, one instruction per item
// an accepted item passes the input register, the execute pass and the result register
// throughput: one item per cycle unless the output stalls, set by the single pass
// the cr, ctr and lr registers update when an item moves into the result register
// reset: asynchronous, clears both stages and sets cr, ctr and lr to zero
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module branch_and_condition_unit (
	input  wire                              clk,
	input  wire                              arst_n,
	input  wire                              s_tvalid,
	output logic                             s_tready,
	// operation[3:0]
	input  wire  [3:0]                       s_tuser,
	// cur_pc[31:0], displacement[57:32], branch_options[62:58], cond_bit[67:63],
	// absolute[68], link[69], dest_bit[74:70], src_a_bit[79:75], src_b_bit[84:80]
	input  wire  [bcu_pkg::IN_DATA_W-1:0]    s_tdata,
	output logic                             m_tvalid,
	input  wire                              m_tready,
	// next_pc[31:0], link_out[63:32], count_out[95:64], cond_out[127:96],
	// taken[128], invalid[129], return_event[130]
	output logic [bcu_pkg::OUT_DATA_W-1:0]   m_tdata
);
	import bcu_pkg::*;

	item_t   item_in;
	item_t   item_s1;
	logic    valid_s1;
	result_t res;
	result_t res_q;
	logic    m_valid_q;
	logic    out_adv;
	logic    load;
	arch_t   arch;
	arch_t   arch_n;

	assign item_in.operation      = op_t'(s_tuser);
	assign item_in.cur_pc         = s_tdata[31:0];
	assign item_in.displacement   = s_tdata[57:32];
	assign item_in.branch_options = s_tdata[62:58];
	assign item_in.cond_bit       = s_tdata[67:63];
	assign item_in.absolute       = s_tdata[68];
	assign item_in.link           = s_tdata[69];
	assign item_in.dest_bit       = s_tdata[74:70];
	assign item_in.src_a_bit      = s_tdata[79:75];
	assign item_in.src_b_bit      = s_tdata[84:80];

	assign out_adv  = !m_valid_q || m_tready;
	assign load     = valid_s1 && out_adv;
	assign s_tready = !valid_s1 || out_adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			item_s1 <= item_in;
		end
	end

	bcu_exec u_exec (
		.item   (item_s1),
		.arch   (arch),
		.arch_n (arch_n),
		.res    (res)
	);

	bcu_arch_regs u_arch (
		.clk    (clk),
		.arst_n (arst_n),
		.load   (load),
		.arch_n (arch_n),
		.arch   (arch)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (out_adv) begin
			m_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			res_q <= res;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = {5'd0, res_q.return_event, res_q.invalid, res_q.taken,
	                   res_q.cond_out, res_q.count_out, res_q.link_out, res_q.next_pc};

endmodule

`default_nettype wire

### hdl/bcu_checker.sv
// ----------------------------------------------------------------------------
// bcu_checker
// port-level checks of the branch and condition unit result stream
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "branch_and_condition_unit_assert.svh"

module bcu_checker (
	input wire         clk,
	input wire         arst_n,
	input wire         m_tvalid,
	input wire         m_tready,
	input wire [135:0] m_tdata
);

	// a stalled item holds
	`BCU_ASSERT(a_out_hold, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))

	// an invalid item neither branches nor returns
	`BCU_ASSERT(a_invalid_quiet, m_tvalid && m_tdata[129] |-> !m_tdata[128] && !m_tdata[130])

	// a return is always a taken branch
	`BCU_ASSERT(a_ret_taken, m_tvalid && m_tdata[130] |-> m_tdata[128])

	// taken targets and the link register are word aligned
	`BCU_ASSERT(a_aligned, m_tvalid |-> m_tdata[33:32] == 2'b00 && (!m_tdata[128] || m_tdata[1:0] == 2'b00))

endmodule

bind branch_and_condition_unit bcu_checker u_bcu_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);

`default_nettype wire

### tb/sv/branch_and_condition_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// branch_and_condition_unit_tb
// self-checking bench for the branch and condition unit: items go in on the
// slave stream, an in-bench model of the cr, ctr and lr registers predicts
// every result item, and the master stream is compared field by field
// ----------------------------------------------------------------------------

module branch_and_condition_unit_tb;

	import bcu_pkg::*;

	localparam int CLK_PERIOD  = 8;
	localparam int CYCLE_LIMIT = 200000;
	localparam int DRAIN_TAIL  = 8;
	localparam int PRINT_CAP   = 50;

	// bo encodings used by the directed items
	localparam logic [4:0] BO_ALWAYS       = 5'b10100;
	localparam logic [4:0] BO_DEC_NZ_FALSE = 5'b00000;
	localparam logic [4:0] BO_DEC_ZERO     = 5'b10010;
	localparam logic [4:0] BO_IF_TRUE      = 5'b01100;
	localparam logic [4:0] BO_IF_FALSE     = 5'b00100;

	logic          clk = 1'b0;
	logic          arst_n = 1'b0;
	logic          s_tvalid = 1'b0;
	logic          s_tready;
	logic [3:0]    s_tuser = '0;
	logic [87:0]   s_tdata = '0;
	logic          m_tvalid;
	logic          m_tready = 1'b0;
	logic [135:0]  m_tdata;

	// architectural state as the bench sees it
	logic [XLEN-1:0] arch_cr = '0;
	logic [XLEN-1:0] arch_ctr = '0;
	logic [XLEN-1:0] arch_lr = '0;

	result_t pending_results[$];
	int      mismatch_count = 0;
	int      cycle_cnt = 0;
	int      src_idle_pct = 0;
	int      sink_idle_pct = 0;

	branch_and_condition_unit u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tuser  (s_tuser),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	initial begin
		forever #(CLK_PERIOD / 2) clk = ~clk;
	end

	always @(posedge clk) cycle_cnt <= cycle_cnt + 1;

	initial begin
		wait (cycle_cnt >= CYCLE_LIMIT);
		$display("Regression FAIL");
		$finish;
	end

	// receiver back-pressure
	always @(negedge clk) begin
		m_tready <= ($urandom_range(99) >= sink_idle_pct);
	end

	function automatic logic cr_bit(input logic [4:0] idx);
		return arch_cr[5'd31 - idx];
	endfunction

	// bo rules: optional ctr decrement and test, optional cr bit test
	function automatic logic bo_test(input logic [4:0] bo, input logic [4:0] bi);
		logic ctr_ok;
		logic cond_ok;
		ctr_ok = 1'b1;
		cond_ok = 1'b1;
		if (!bo[BO_NO_DEC]) begin
			arch_ctr = arch_ctr - 32'd1;
			ctr_ok = ((arch_ctr == '0) == bo[BO_CTR_ZERO]);
		end
		if (!bo[BO_NO_COND])
			cond_ok = (cr_bit(bi) == bo[BO_COND_VAL]);
		return ctr_ok && cond_ok;
	endfunction

	// executes one instruction on the bench state and returns its result item
	function automatic result_t execute_instr(input item_t it);
		result_t         r;
		logic [XLEN-1:0] disp_ext;
		logic [XLEN-1:0] target;
		logic            go;
		logic            a;
		logic            b;
		logic            v;
		int unsigned     src_sh;
		int unsigned     dst_sh;
		logic [3:0]      fld;
		disp_ext = {{(XLEN - DISP_W){it.displacement[DISP_W-1]}}, it.displacement};
		r = '0;
		r.next_pc = it.cur_pc;
		case (it.operation)
			OP_B, OP_BC, OP_BCLR, OP_BCCTR: begin
				if (it.operation == OP_BCCTR && !it.branch_options[BO_NO_DEC]) begin
					r.invalid = 1'b1;
				end else begin
					target = it.absolute ? disp_ext : it.cur_pc + disp_ext;
					// bclr uses the link value from before this item
					if (it.operation == OP_BCLR)
						target = arch_lr;
					else if (it.operation == OP_BCCTR)
						target = arch_ctr;
					go = (it.operation == OP_B) ? 1'b1 :
						bo_test(it.branch_options, it.cond_bit);
					if (it.link)
						arch_lr = (it.cur_pc + PC_STEP) & ADDR_MASK;
					if (go) begin
						r.next_pc = target & ADDR_MASK;
						r.taken = 1'b1;
					end else begin
						r.next_pc = it.cur_pc + PC_STEP;
					end
					r.return_event = (it.operation == OP_BCLR) && go &&
						it.branch_options[BO_NO_DEC];
				end
			end
			OP_CRAND, OP_CRANDC, OP_CREQV, OP_CROR, OP_CRORC, OP_CRNAND, OP_CRNOR,
			OP_CRXOR: begin
				a = cr_bit(it.src_a_bit);
				b = cr_bit(it.src_b_bit);
				case (it.operation)
					OP_CRAND:  v = a & b;
					OP_CRANDC: v = a & ~b;
					OP_CREQV:  v = ~(a ^ b);
					OP_CROR:   v = a | b;
					OP_CRORC:  v = a | ~b;
					OP_CRNAND: v = ~(a & b);
					OP_CRNOR:  v = ~(a | b);
					default:   v = a ^ b;
				endcase
				arch_cr[5'd31 - it.dest_bit] = v;
			end
			OP_MCRF: begin
				// field 0 is the top nibble
				src_sh = (7 - it.src_a_bit[2:0]) * 4;
				dst_sh = (7 - it.dest_bit[2:0]) * 4;
				fld = arch_cr[src_sh +: 4];
				arch_cr[dst_sh +: 4] = fld;
			end
			default: ;
		endcase
		r.link_out = arch_lr;
		r.count_out = arch_ctr;
		r.cond_out = arch_cr;
		return r;
	endfunction

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		if (mismatch_count < PRINT_CAP)
			$display("[%0t] mismatch %s: got %h want %h", $realtime, what, got, want);
		mismatch_count++;
	endtask

	task automatic check_field(input string what, input logic [31:0] got,
			input logic [31:0] want);
		if (got !== want)
			report_mismatch(what, got, want);
	endtask

	always @(posedge clk) begin : check_results
		result_t got;
		result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			got.next_pc      = m_tdata[31:0];
			got.link_out     = m_tdata[63:32];
			got.count_out    = m_tdata[95:64];
			got.cond_out     = m_tdata[127:96];
			got.taken        = m_tdata[128];
			got.invalid      = m_tdata[129];
			got.return_event = m_tdata[130];
			if (pending_results.size() == 0) begin
				report_mismatch("unexpected item", got.next_pc, '0);
			end else begin
				want = pending_results.pop_front();
				check_field("next_pc", got.next_pc, want.next_pc);
				check_field("link_out", got.link_out, want.link_out);
				check_field("count_out", got.count_out, want.count_out);
				check_field("cond_out", got.cond_out, want.cond_out);
				check_field("taken", 32'(got.taken), 32'(want.taken));
				check_field("invalid", 32'(got.invalid), 32'(want.invalid));
				check_field("return_event", 32'(got.return_event),
					32'(want.return_event));
			end
		end
	end

	// called at a falling edge, returns at the falling edge after the accept
	task automatic send_item(input item_t it);
		while ($urandom_range(99) < src_idle_pct) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= it.operation;
		s_tdata  <= {3'b000, it.src_b_bit, it.src_a_bit, it.dest_bit, it.link,
			it.absolute, it.cond_bit, it.branch_options, it.displacement, it.cur_pc};
		do @(posedge clk); while (!s_tready);
		pending_results.push_back(execute_instr(it));
		@(negedge clk);
	endtask

	task automatic wait_results_drained();
		s_tvalid <= 1'b0;
		while (pending_results.size() != 0) @(negedge clk);
	endtask

	function automatic item_t make_item(input op_t op, input logic [31:0] pc,
			input logic [25:0] disp, input logic [4:0] bo, input logic [4:0] bi,
			input logic aa, input logic lk, input logic [4:0] bt,
			input logic [4:0] ba, input logic [4:0] bb);
		item_t it;
		it.operation      = op;
		it.cur_pc         = pc;
		it.displacement   = disp;
		it.branch_options = bo;
		it.cond_bit       = bi;
		it.absolute       = aa;
		it.link           = lk;
		it.dest_bit       = bt;
		it.src_a_bit      = ba;
		it.src_b_bit      = bb;
		return it;
	endfunction

	task automatic test_branch_targets();
		// largest forward offset with link
		send_item(make_item(OP_B, 32'h0000_1000, 26'h1FF_FFFF, 5'd0, 5'd0, 1'b0, 1'b1,
			5'd0, 5'd0, 5'd0));
		// pc wraps past the top of the address space
		send_item(make_item(OP_B, 32'hFFFF_FFFC, 26'd8, 5'd0, 5'd0, 1'b0, 1'b0,
			5'd0, 5'd0, 5'd0));
		// absolute, most negative displacement
		send_item(make_item(OP_B, 32'h1234_5678, 26'h200_0000, 5'd0, 5'd0, 1'b1, 1'b0,
			5'd0, 5'd0, 5'd0));
		// absolute -1, low bits cleared, bo and bi ignored
		send_item(make_item(OP_B, 32'h0000_0040, 26'h3FF_FFFF, 5'h1F, 5'h1F, 1'b1, 1'b1,
			5'h1F, 5'h1F, 5'h1F));
		send_item(make_item(OP_BC, 32'h8000_0000, 26'h3FF_FFFC, BO_ALWAYS, 5'd0, 1'b0,
			1'b0, 5'd0, 5'd0, 5'd0));
		// decrement from zero wraps the counter, cr bit 0 is clear
		send_item(make_item(OP_BC, 32'h0000_2000, 26'd64, BO_DEC_NZ_FALSE, 5'd0, 1'b0,
			1'b1, 5'd0, 5'd0, 5'd0));
		// condition must be set but cr bit is clear: falls through
		send_item(make_item(OP_BC, 32'hFFFF_FFFC, 26'd64, BO_IF_TRUE, 5'd31, 1'b0,
			1'b0, 5'd0, 5'd0, 5'd0));
	endtask

	task automatic test_condition_logic();
		send_item(make_item(OP_CREQV, 32'h100, '0, 5'd0, 5'd0, 1'b0, 1'b0,
			5'd0, 5'd31, 5'd31));
		send_item(make_item(OP_CRNOR, 32'h104, '0, 5'd0, 5'd0, 1'b0, 1'b0,
			5'd31, 5'd5, 5'd6));
		send_item(make_item(OP_CROR, 32'h108, '0, 5'd0, 5'd0, 1'b0, 1'b0,
			5'd10, 5'd0, 5'd1));
		send_item(make_item(OP_CRAND, 32'h10C, '0, 5'd0, 5'd0, 1'b0, 1'b0,
			5'd16, 5'd10, 5'd31));
		send_item(make_item(OP_CRANDC, 32'h110, '0, 5'd0, 5'd0, 1'b0, 1'b0,
			5'd21, 5'd0, 5'd2));
		send_item(make_item(OP_CRORC, 32'h114, '0, 5'd0, 5'd0, 1'b0, 1'b0,
			5'd3, 5'd4, 5'd0));
		send_item(make_item(OP_CRNAND, 32'h118, '0, 5'd0, 5'd0, 1'b0, 1'b0,
			5'd7, 5'd0, 5'd0));
		send_item(make_item(OP_CRXOR, 32'h11C, '0, 5'd0, 5'd0, 1'b0, 1'b0,
			5'd0, 5'd0, 5'd31));
		// field numbers use only the low three bits, src_b ignored
		send_item(make_item(OP_MCRF, 32'h120, '0, 5'd0, 5'd0, 1'b0, 1'b0,
			5'b11111, 5'b01000, 5'h1F));
		send_item(make_item(OP_MCRF, 32'h124, '0, 5'd0, 5'd0, 1'b0, 1'b0,
			5'b10010, 5'b00111, 5'd0));
	endtask

	task automatic test_special_cases();
		// cr bit 1 set by the eqv here with bit 0 cleared by xor: test a true bit
		send_item(make_item(OP_CREQV, 32'h200, '0, 5'd0, 5'd0, 1'b0, 1'b0,
			5'd1, 5'd2, 5'd2));
		send_item(make_item(OP_BC, 32'h204, 26'd16, BO_IF_TRUE, 5'd1, 1'b0, 1'b1,
			5'd0, 5'd0, 5'd0));
		// return through the link register
		send_item(make_item(OP_BCLR, 32'h3000, '0, BO_ALWAYS, 5'd0, 1'b0, 1'b1,
			5'd0, 5'd0, 5'd0));
		// bclr with decrement: taken but no return flag
		send_item(make_item(OP_BCLR, 32'h3004, '0, BO_DEC_NZ_FALSE, 5'd2, 1'b0, 1'b0,
			5'd0, 5'd0, 5'd0));
		// bcctr asking for a decrement: no state change
		send_item(make_item(OP_BCCTR, 32'h3008, '0, BO_DEC_NZ_FALSE, 5'd0, 1'b0, 1'b1,
			5'd0, 5'd0, 5'd0));
		send_item(make_item(OP_BCCTR, 32'h300C, '0, BO_IF_FALSE, 5'd0, 1'b0, 1'b1,
			5'd0, 5'd0, 5'd0));
		// branch on zero counter, counter is far from zero
		send_item(make_item(OP_BC, 32'h3010, 26'd32, BO_DEC_ZERO, 5'd0, 1'b0, 1'b0,
			5'd0, 5'd0, 5'd0));
	endtask

	task automatic test_random_stream(input int n_items, input int src_pct,
			input int sink_pct);
		item_t it;
		// hold off until the pipe is empty before changing the idle mix
		wait_results_drained();
		src_idle_pct = src_pct;
		sink_idle_pct = sink_pct;
		repeat (n_items) begin
			it.operation      = op_t'(4'($urandom_range(OP_MCRF)));
			it.cur_pc         = ($urandom_range(7) == 0) ?
				(32'hFFFF_FFF0 | 32'($urandom_range(15))) : $urandom;
			it.displacement   = 26'($urandom);
			it.branch_options = 5'($urandom);
			it.cond_bit       = 5'($urandom);
			it.absolute       = 1'($urandom);
			it.link           = 1'($urandom);
			it.dest_bit       = 5'($urandom);
			it.src_a_bit      = 5'($urandom);
			it.src_b_bit      = 5'($urandom);
			send_item(it);
		end
	endtask

	initial begin
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		sink_idle_pct = 30;
		test_branch_targets();
		test_condition_logic();
		test_special_cases();

		test_random_stream(500, 23, 49);
		test_random_stream(500, 49, 23);
		test_random_stream(500, 0, 0);

		wait_results_drained();
		repeat (DRAIN_TAIL) @(posedge clk);
		if (mismatch_count == 0 && pending_results.size() == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

endmodule
